/* src/coap_mp_pkg.sv */
`default_nettype none
package coap_mp_pkg;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PhHdr  = 8'b0000_0001,
    PhTok  = 8'b0000_0010,
    PhHead = 8'b0000_0100,
    PhDext = 8'b0000_1000,
    PhLext = 8'b0001_0000,
    PhVal  = 8'b0010_0000,
    PhPay  = 8'b0100_0000,
    PhStop = 8'b1000_0000
  } phase_e;

  // Result classification codes
  localparam logic [2:0] KindHeader  = 3'd0;
  localparam logic [2:0] KindToken   = 3'd1;
  localparam logic [2:0] KindOptHead = 3'd2;
  localparam logic [2:0] KindOptVal  = 3'd3;
  localparam logic [2:0] KindMarker  = 3'd4;
  localparam logic [2:0] KindPayload = 3'd5;
  localparam logic [2:0] KindIgnored = 3'd6;

  // Error flag bit positions
  localparam int unsigned ErrShort    = 0;
  localparam int unsigned ErrVersion  = 1;
  localparam int unsigned ErrTokLen   = 2;
  localparam int unsigned ErrReserved = 3;
  localparam int unsigned ErrTrunc    = 4;
  localparam int unsigned ErrOverflow = 5;

  // Header byte positions
  localparam logic [1:0] HdrFirst = 2'd0;
  localparam logic [1:0] HdrCode  = 2'd1;
  localparam logic [1:0] HdrIdHi  = 2'd2;
  localparam logic [1:0] HdrIdLo  = 2'd3;

  localparam logic [1:0]  CoapVersion   = 2'd1;
  localparam logic [3:0]  MaxTokenBytes = 4'd8;
  localparam logic [7:0]  MarkerByte    = 8'hFF;
  localparam logic [3:0]  NibbleExt8    = 4'd13;
  localparam logic [3:0]  NibbleExt16   = 4'd14;
  localparam logic [3:0]  NibbleRsvd    = 4'd15;
  localparam logic [16:0] Ext8Offset    = 17'd13;
  localparam logic [16:0] Ext16Offset   = 17'd269;
  localparam logic [15:0] OptNumMax     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_payload_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  data_byte;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [1:0]  version;
    logic [1:0]  message_type;
    logic [3:0]  token_length;
    logic [7:0]  code;
    logic [15:0] msg_ident;
    logic [5:0]  error_flags;
    logic        message_done;
  } out_payload_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  hdr_cnt;
    logic [3:0]  tok_left;
    logic [15:0] cur_opt;
    logic [3:0]  pend_len;
    logic [15:0] ext_acc;
    logic [1:0]  ext_left;
    logic        ext_wide;
    logic [16:0] val_left;
    logic [16:0] opt_len;
    logic [1:0]  version;
    logic [1:0]  mtype;
    logic [3:0]  tok_len;
    logic [7:0]  code;
    logic [15:0] msg_id;
    logic [5:0]  err;
  } parser_state_t;

  function automatic parser_state_t reset_state();
    parser_state_t s;
    s       = '0;
    s.phase = PhHdr;
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/coap_ifs.sv */
`default_nettype none
interface coap_byte_if;
  import coap_mp_pkg::*;
  logic        valid;
  logic        ready;
  in_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface coap_result_if;
  import coap_mp_pkg::*;
  logic         valid;
  logic         ready;
  out_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/coap_message_parser_top.sv */
`default_nettype none
// Channel   Dir  Payload                                      Transaction
// in_i      in   byte_value[7:0], last_byte                   valid & ready
// out_o     out  item_kind .. message_done (one per byte)     valid & ready
//
// One byte per cycle while the output is free or being taken: each byte is
// decoded in the cycle it is accepted and its result lands in the output
// register on the next edge. The parser state register is the only loop.
// Reset (rst_ni low) clears the state to the header phase and empties the
// output register. A stalled output holds its result; a new byte is still
// accepted in the cycle in which the held result is taken.
module coap_message_parser_top (
  input  wire           clk_i,
  input  wire           rst_ni,
  coap_byte_if.sink     in_i,
  coap_result_if.source out_o
);
  import coap_mp_pkg::*;

  parser_state_t state_q, state_d;
  out_payload_t  result_d, result_q;
  logic          out_valid_q;
  logic          accept;

  // Take a byte whenever the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  coap_mp_core u_core (
    .state_i  (state_q),
    .in_i     (in_i.payload),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Advance the parser state only on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= reset_state();
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = result_q;

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.payload.last_byte |=> state_q.phase == PhHdr && state_q.hdr_cnt == HdrFirst)
    else $error("parser did not restart after last byte");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && result_q.data_byte == $past(in_i.payload.byte_value))
    else $error("accepted byte missing from result register");

  a_hdr_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != PhHdr |-> state_q.hdr_cnt == HdrIdLo)
    else $error("left header phase before four header bytes");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("parser state moved without a transaction");
`endif

endmodule
`default_nettype wire

/* src/coap_mp_core.sv */
`default_nettype none
module coap_mp_core (
  input  coap_mp_pkg::parser_state_t state_i,
  input  coap_mp_pkg::in_payload_t   in_i,
  output coap_mp_pkg::parser_state_t state_o,
  output coap_mp_pkg::out_payload_t  result_o
);
  import coap_mp_pkg::*;

  parser_state_t s;
  logic [2:0]    kind;
  logic [7:0]    b;
  logic          do_delta;
  logic [16:0]   delta_val;
  logic          do_len;
  logic [16:0]   len_val;
  logic          do_ext;
  logic [3:0]    ext_nib;
  phase_e        ext_phase;
  logic [17:0]   opt_sum;
  logic [16:0]   ext_val;

  always_comb begin
    s         = state_i;
    b         = in_i.byte_value;
    kind      = KindIgnored;
    do_delta  = 1'b0;
    delta_val = '0;
    do_len    = 1'b0;
    len_val   = '0;
    do_ext    = 1'b0;
    ext_nib   = '0;
    ext_phase = PhDext;
    opt_sum   = '0;
    ext_val   = '0;

    case (s.phase)
      PhHdr: begin
        kind = KindHeader;
        case (s.hdr_cnt)
          HdrFirst: begin
            s.version  = b[7:6];
            s.mtype    = b[5:4];
            s.tok_len  = b[3:0];
            s.tok_left = b[3:0];
            if (b[7:6] != CoapVersion) s.err[ErrVersion] = 1'b1;
            if (b[3:0] > MaxTokenBytes) s.err[ErrTokLen] = 1'b1;
          end
          HdrCode: s.code   = b;
          HdrIdHi: s.msg_id = {b, 8'h00};
          default: s.msg_id = {s.msg_id[15:8], s.msg_id[7:0] | b};
        endcase
        if (s.hdr_cnt == HdrIdLo) begin
          s.phase = (s.tok_left != 4'd0) ? PhTok : PhHead;
        end else begin
          s.hdr_cnt = s.hdr_cnt + 2'd1;
        end
      end
      PhTok: begin
        kind       = KindToken;
        s.tok_left = s.tok_left - 4'd1;
        if (s.tok_left == 4'd0) s.phase = PhHead;
      end
      PhHead: begin
        if (b == MarkerByte) begin
          kind    = KindMarker;
          s.phase = PhPay;
          if (in_i.last_byte) s.err[ErrReserved] = 1'b1;
        end else begin
          kind = KindOptHead;
          if (b[7:4] == NibbleRsvd || b[3:0] == NibbleRsvd) begin
            s.err[ErrReserved] = 1'b1;
            s.phase            = PhStop;
          end else begin
            s.pend_len = b[3:0];
            if (b[7:4] < NibbleExt8) begin
              do_delta  = 1'b1;
              delta_val = {13'd0, b[7:4]};
            end else begin
              do_ext    = 1'b1;
              ext_nib   = b[7:4];
              ext_phase = PhDext;
            end
          end
        end
      end
      PhDext, PhLext: begin
        kind       = KindOptHead;
        s.ext_acc  = {s.ext_acc[7:0], b};
        s.ext_left = s.ext_left - 2'd1;
        if (s.ext_left == 2'd0) begin
          ext_val = {1'b0, s.ext_acc} + (s.ext_wide ? Ext16Offset : Ext8Offset);
          if (s.phase == PhDext) begin
            do_delta  = 1'b1;
            delta_val = ext_val;
          end else begin
            do_len  = 1'b1;
            len_val = ext_val;
          end
        end
      end
      PhVal: begin
        kind       = KindOptVal;
        s.val_left = s.val_left - 17'd1;
        if (s.val_left == 17'd0) s.phase = PhHead;
      end
      PhPay:   kind = KindPayload;
      default: kind = KindIgnored;
    endcase

    // Accumulate the option delta, saturating on overflow
    if (do_delta) begin
      opt_sum = {2'b00, s.cur_opt} + {1'b0, delta_val};
      if (opt_sum > {2'b00, OptNumMax}) begin
        s.err[ErrOverflow] = 1'b1;
        s.cur_opt          = OptNumMax;
      end else begin
        s.cur_opt = opt_sum[15:0];
      end
      if (s.pend_len < NibbleExt8) begin
        do_len  = 1'b1;
        len_val = {13'd0, s.pend_len};
      end else begin
        do_ext    = 1'b1;
        ext_nib   = s.pend_len;
        ext_phase = PhLext;
      end
    end

    if (do_len) begin
      s.opt_len  = len_val;
      s.val_left = len_val;
      s.phase    = (len_val == 17'd0) ? PhHead : PhVal;
    end

    if (do_ext) begin
      s.ext_wide = (ext_nib == NibbleExt16);
      s.ext_left = (ext_nib == NibbleExt16) ? 2'd2 : 2'd1;
      s.ext_acc  = '0;
      s.phase    = ext_phase;
    end

    if (in_i.last_byte) begin
      if (s.phase == PhHdr) begin
        s.err[ErrShort] = 1'b1;
      end else if (s.phase inside {PhTok, PhDext, PhLext, PhVal}) begin
        s.err[ErrTrunc] = 1'b1;
      end
    end

    result_o.item_kind     = kind;
    result_o.data_byte     = b;
    result_o.option_number = s.cur_opt;
    result_o.option_length = s.opt_len;
    result_o.version       = s.version;
    result_o.message_type  = s.mtype;
    result_o.token_length  = s.tok_len;
    result_o.code          = s.code;
    result_o.msg_ident     = s.msg_id;
    result_o.error_flags   = s.err;
    result_o.message_done  = in_i.last_byte;

    // Return to the idle header phase after the last byte
    state_o = in_i.last_byte ? reset_state() : s;
  end

endmodule
`default_nettype wire

/* sim/coap_message_parser_top_tb.sv */
module coap_message_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import coap_mp_pkg::*;

  // Bytes of random datagrams to push after the directed part
  localparam int unsigned RandomBytes = 800;
  // Cycles without any transaction before the run is declared hung
  localparam int unsigned StallLimit  = 1000;
  // Cycles to hold after the last expected result (output register depth is one)
  localparam int unsigned DrainCycles = 10;
  // Percent of cycles in which a side idles
  localparam int unsigned GapPercent  = 18;

  // Tracks the parser state byte by byte and holds the results it predicts.
  class coap_parse_tracker;
    phase_e      phase;
    logic [1:0]  hdr_idx;
    logic [3:0]  tok_left;
    logic [15:0] opt_num;
    logic [3:0]  len_nib;
    logic [15:0] ext_acc;
    logic [1:0]  ext_left;
    logic        ext_wide;
    logic [16:0] val_left;
    logic [16:0] opt_len;
    logic [1:0]  ver;
    logic [1:0]  mtype;
    logic [3:0]  tkl;
    logic [7:0]  code;
    logic [15:0] mid;
    logic [5:0]  err;
    out_payload_t byte_results_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase    = PhHdr;
      hdr_idx  = HdrFirst;
      tok_left = '0;
      opt_num  = '0;
      len_nib  = '0;
      ext_acc  = '0;
      ext_left = '0;
      ext_wide = 1'b0;
      val_left = '0;
      opt_len  = '0;
      ver      = '0;
      mtype    = '0;
      tkl      = '0;
      code     = '0;
      mid      = '0;
      err      = '0;
    endfunction

    function int unsigned pending();
      return byte_results_q.size();
    endfunction

    function void start_ext(logic [3:0] nib, phase_e next_phase);
      ext_wide = (nib == NibbleExt16);
      ext_left = ext_wide ? 2'd2 : 2'd1;
      ext_acc  = '0;
      phase    = next_phase;
    endfunction

    function void take_length(int unsigned len);
      opt_len  = len[16:0];
      val_left = opt_len;
      phase    = (opt_len == 0) ? PhHead : PhVal;
    endfunction

    function void add_delta(int unsigned delta);
      int unsigned sum;
      sum = opt_num + delta;
      // saturate the option number and flag it
      if (sum > OptNumMax) begin
        err[ErrOverflow] = 1'b1;
        sum = OptNumMax;
      end
      opt_num = sum[15:0];
      if (len_nib < NibbleExt8) take_length(len_nib);
      else start_ext(len_nib, PhLext);
    endfunction

    function void note_byte(in_payload_t in);
      out_payload_t res;
      logic [7:0]   b;
      logic [2:0]   kind;
      int unsigned  ext_sum;
      b    = in.byte_value;
      kind = KindIgnored;
      case (phase)
        PhHdr: begin
          kind = KindHeader;
          case (hdr_idx)
            HdrFirst: begin
              ver   = b[7:6];
              mtype = b[5:4];
              tkl   = b[3:0];
              if (ver != CoapVersion) err[ErrVersion] = 1'b1;
              if (tkl > MaxTokenBytes) err[ErrTokLen] = 1'b1;
              tok_left = tkl;
            end
            HdrCode: code = b;
            HdrIdHi: mid = {b, 8'h00};
            default: mid = {mid[15:8], b};
          endcase
          if (hdr_idx == HdrIdLo) phase = (tok_left != 0) ? PhTok : PhHead;
          else hdr_idx = hdr_idx + 2'd1;
        end
        PhTok: begin
          kind     = KindToken;
          tok_left = tok_left - 4'd1;
          if (tok_left == 0) phase = PhHead;
        end
        PhHead: begin
          if (b == MarkerByte) begin
            kind  = KindMarker;
            phase = PhPay;
            // marker with nothing after it
            if (in.last_byte) err[ErrReserved] = 1'b1;
          end else begin
            kind = KindOptHead;
            if (b[7:4] == NibbleRsvd || b[3:0] == NibbleRsvd) begin
              err[ErrReserved] = 1'b1;
              phase = PhStop;
            end else begin
              len_nib = b[3:0];
              if (b[7:4] < NibbleExt8) add_delta(b[7:4]);
              else start_ext(b[7:4], PhDext);
            end
          end
        end
        PhDext, PhLext: begin
          kind     = KindOptHead;
          ext_acc  = {ext_acc[7:0], b};
          ext_left = ext_left - 2'd1;
          if (ext_left == 0) begin
            ext_sum = ext_acc + (ext_wide ? Ext16Offset : Ext8Offset);
            if (phase == PhDext) add_delta(ext_sum);
            else take_length(ext_sum);
          end
        end
        PhVal: begin
          kind     = KindOptVal;
          val_left = val_left - 17'd1;
          if (val_left == 0) phase = PhHead;
        end
        PhPay: kind = KindPayload;
        default: kind = KindIgnored;
      endcase

      if (in.last_byte) begin
        if (phase == PhHdr) err[ErrShort] = 1'b1;
        else if (phase inside {PhTok, PhDext, PhLext, PhVal}) err[ErrTrunc] = 1'b1;
      end

      res.item_kind     = kind;
      res.data_byte     = b;
      res.option_number = opt_num;
      res.option_length = opt_len;
      res.version       = ver;
      res.message_type  = mtype;
      res.token_length  = tkl;
      res.code          = code;
      res.msg_ident     = mid;
      res.error_flags   = err;
      res.message_done  = in.last_byte;
      byte_results_q.push_back(res);

      // the next datagram starts from a clean parser
      if (in.last_byte) clear();
    endfunction

    function void report_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(out_payload_t got);
      out_payload_t exp;
      if (byte_results_q.size() == 0) begin
        $display("%0t: result for byte 0x%0h with none expected, expected nothing actual 0x%0h",
                 $time, got.data_byte, got);
        mismatches++;
        return;
      end
      exp = byte_results_q.pop_front();
      report_field("item_kind",     exp.item_kind,     got.item_kind);
      report_field("data_byte",     exp.data_byte,     got.data_byte);
      report_field("option_number", exp.option_number, got.option_number);
      report_field("option_length", exp.option_length, got.option_length);
      report_field("version",       exp.version,       got.version);
      report_field("message_type",  exp.message_type,  got.message_type);
      report_field("token_length",  exp.token_length,  got.token_length);
      report_field("code",          exp.code,          got.code);
      report_field("msg_ident",     exp.msg_ident,     got.msg_ident);
      report_field("error_flags",   exp.error_flags,   got.error_flags);
      report_field("message_done",  exp.message_done,  got.message_done);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  coap_byte_if   in_if ();
  coap_result_if out_if ();

  coap_message_parser_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  coap_parse_tracker tracker = new();

  logic [7:0]  dgram_q[$];   // bytes of the datagram being pushed
  int unsigned bytes_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          no_gaps      = 1'b0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < GapPercent);
  endfunction

  // Result side: drop ready at random on the falling edge; hold it high in the
  // stretch without gaps.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = !take_gap();
    end
  end

  // Sample both channels at the rising edge. Note the accepted byte first so a
  // result can never be checked ahead of its own prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) tracker.note_byte(in_if.payload);
      if (out_if.valid && out_if.ready) tracker.check_result(out_if.payload);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  // Watchdog: end the run when no transaction happens for too long.
  initial begin
    wait (stall_cycles >= StallLimit);
    $display("** coap_message_parser_top: FAILED **");
    $finish;
  end

  // Push one byte: idle at random, then hold valid until the transaction.
  // Enter and leave on the falling edge.
  task automatic push_byte(input logic [7:0] value, input logic is_last);
    while (take_gap()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.payload = {value, is_last};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_datagram();
    for (int i = 0; i < dgram_q.size(); i++) push_byte(dgram_q[i], i == dgram_q.size() - 1);
  endtask

  // Build a datagram in dgram_q. A well-formed one has a version 1 header
  // (mostly), a token, a few options and maybe a payload. A broken one allows
  // huge option lengths under a byte cap, then gets cut short or has one byte
  // overwritten.
  function automatic void build_random_datagram(bit broken);
    int unsigned tkl;
    int unsigned dnib;
    int unsigned lnib;
    int unsigned ext_val;
    int unsigned n_val;
    int unsigned cap;
    int unsigned cut;
    int unsigned pick;
    logic [1:0]  ver;
    dgram_q.delete();
    cap = broken ? 40 : 400;
    ver = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : CoapVersion;
    tkl = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    dgram_q.push_back({ver, 2'($urandom_range(0, 3)), 4'(tkl)});
    // code, message id and token bytes
    repeat (3 + tkl) dgram_q.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(0, 9);
      dnib = (pick < 6) ? $urandom_range(0, 12) : (pick < 9) ? NibbleExt8 : NibbleExt16;
      pick = $urandom_range(0, 24);
      lnib = (pick < 18) ? $urandom_range(0, 12) : (pick < 24) ? NibbleExt8 : NibbleExt16;
      dgram_q.push_back({4'(dnib), 4'(lnib)});
      if (dnib == NibbleExt8) begin
        dgram_q.push_back(8'($urandom));
      end else if (dnib == NibbleExt16) begin
        dgram_q.push_back(8'($urandom));
        dgram_q.push_back(8'($urandom));
      end
      n_val = lnib;
      if (lnib == NibbleExt8) begin
        ext_val = broken ? $urandom_range(0, 255) : $urandom_range(0, 20);
        dgram_q.push_back(8'(ext_val));
        n_val = ext_val + Ext8Offset;
      end else if (lnib == NibbleExt16) begin
        ext_val = broken ? $urandom_range(0, 65535) : $urandom_range(0, 15);
        dgram_q.push_back(8'(ext_val >> 8));
        dgram_q.push_back(8'(ext_val));
        n_val = ext_val + Ext16Offset;
      end
      for (int k = 0; k < n_val && dgram_q.size() < cap; k++) dgram_q.push_back(8'($urandom));
    end
    // payload marker; zero payload bytes leaves the marker last
    if ($urandom_range(0, 1) == 1) begin
      dgram_q.push_back(MarkerByte);
      repeat ($urandom_range(0, 6)) dgram_q.push_back(8'($urandom));
    end
    if (broken) begin
      if ($urandom_range(0, 1) == 1) begin
        cut = $urandom_range(1, dgram_q.size());
        while (dgram_q.size() > cut) void'(dgram_q.pop_back());
      end else begin
        dgram_q[$urandom_range(0, dgram_q.size() - 1)] = 8'($urandom);
      end
    end
  endfunction

  initial begin
    int unsigned pick;
    in_if.valid   = 1'b0;
    in_if.payload = '0;

    // hold reset, then release it on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // header only, no error
    dgram_q = {8'h40, 8'h01, 8'h00, 8'h00};
    send_datagram();
    // single all-ones byte: short header, version 3, token length 15
    dgram_q = {8'hFF};
    send_datagram();
    // one token byte, then a marker as the last byte
    dgram_q = {8'h41, 8'h45, 8'hAB, 8'hCD, 8'h7E, 8'hFF};
    send_datagram();
    // wide delta extension overflows the option number, then a reserved
    // nibble stops parsing and the rest is ignored
    dgram_q = {8'h60, 8'h00, 8'h12, 8'h34, 8'hE0, 8'hFF, 8'hFF, 8'hF1, 8'h55};
    send_datagram();
    // narrow delta extension with one value byte, empty option, payload
    dgram_q = {8'h50, 8'h02, 8'h00, 8'h01, 8'hD1, 8'h00, 8'h9A, 8'h10, 8'hFF, 8'h33};
    send_datagram();

    // Random datagrams: mostly well-formed, the rest broken or plain noise.
    // A window in the middle runs with no idling on either side.
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      no_gaps = (bytes_sent >= 300 && bytes_sent < 450);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_random_datagram(1'b0);
      end else if (pick < 85) begin
        build_random_datagram(1'b1);
      end else begin
        dgram_q.delete();
        repeat ($urandom_range(1, 10)) dgram_q.push_back(8'($urandom));
      end
      send_datagram();
    end
    no_gaps     = 1'b0;
    in_if.valid = 1'b0;

    // drain: wait for every predicted result, then hold for DrainCycles
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("** coap_message_parser_top: PASSED **");
    end else begin
      $display("** coap_message_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

/* coap_message_parser_top.f */
src/coap_mp_pkg.sv
src/coap_ifs.sv
src/coap_mp_core.sv
src/coap_message_parser_top.sv
sim/coap_message_parser_top_tb.sv
